[design/pmms_pkg.sv]
package pmms_pkg;

	localparam int MaxSamples  = 1024;
	localparam int SampleWidth = 24;
	localparam int AddrWidth   = $clog2(MaxSamples);
	localparam int CountWidth  = AddrWidth + 1;
	localparam int SumWidth    = SampleWidth + CountWidth;
	localparam int DiffWidth   = SampleWidth + 1;
	localparam int SqWidth     = 2 * DiffWidth;
	localparam int AccWidth    = 60;
	localparam int OutCntWidth = 11;

	typedef struct packed {
		logic load;
		logic clear;
		logic div_start;
		logic pass_start;
		logic var_start;
		logic root_start;
	} ctl_t;

	typedef struct packed {
		logic div_done;
		logic pass_done;
		logic var_done;
		logic root_done;
	} sts_t;

endpackage

[design/pmms_stream_if.sv]
interface pmms_stream_if #(
	parameter int Width = 1
);
	logic             valid;
	logic             ready;
	logic [Width-1:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[design/pmms_ctrl.sv]
module pmms_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output pmms_pkg::ctl_t   ctl,
	input  pmms_pkg::sts_t   sts
);
	typedef enum logic [2:0] {
		ST_LOAD, ST_DIV, ST_PASS, ST_VAR, ST_ROOT, ST_OUT
	} state_t;

	state_t state_q;
	logic   start_q;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		ctl            = '0;
		ctl.load       = in_valid && in_ready;
		ctl.clear      = out_valid && out_ready;
		ctl.div_start  = start_q && (state_q == ST_DIV);
		ctl.pass_start = start_q && (state_q == ST_PASS);
		ctl.var_start  = start_q && (state_q == ST_VAR);
		ctl.root_start = start_q && (state_q == ST_ROOT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			start_q <= 1'b0;
		end else begin
			// one-cycle start pulse on entry to each compute state
			start_q <= ((state_q == ST_LOAD) && in_valid && in_last) ||
			           ((state_q == ST_DIV) && sts.div_done) ||
			           ((state_q == ST_PASS) && sts.pass_done) ||
			           ((state_q == ST_VAR) && sts.var_done);
			case (state_q)
				ST_LOAD: if (in_valid && in_last) state_q <= ST_DIV;
				ST_DIV:  if (sts.div_done) state_q <= ST_PASS;
				ST_PASS: if (sts.pass_done) state_q <= ST_VAR;
				ST_VAR:  if (sts.var_done) state_q <= ST_ROOT;
				ST_ROOT: if (sts.root_done) state_q <= ST_OUT;
				ST_OUT:  if (out_ready) state_q <= ST_LOAD;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_start_one: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> !start_q) else $error("start held");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !out_valid) else $error("load while busy");
	a_clear_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> in_ready) else $error("no return to load");
endmodule

[design/pmms_datapath.sv]
module pmms_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pmms_pkg::ctl_t                       ctl,
	output pmms_pkg::sts_t                       sts,
	input  logic signed [pmms_pkg::SampleWidth-1:0] sample,
	output logic signed [pmms_pkg::SampleWidth-1:0] min_out,
	output logic signed [pmms_pkg::SampleWidth-1:0] max_out,
	output logic signed [pmms_pkg::SampleWidth-1:0] mean_out,
	output logic        [pmms_pkg::SampleWidth-1:0] sd_out,
	output logic        [pmms_pkg::OutCntWidth-1:0] count_out,
	output logic                                 ovf_out
);
	localparam int SW = pmms_pkg::SampleWidth;
	localparam int AW = pmms_pkg::AddrWidth;
	localparam int CW = pmms_pkg::CountWidth;
	localparam int UW = pmms_pkg::SumWidth;
	localparam int DW = pmms_pkg::DiffWidth;
	localparam int QW = pmms_pkg::SqWidth;
	localparam int XW = pmms_pkg::AccWidth;
	localparam int RW = XW / 2;
	localparam logic [CW-1:0] Full = CW'(pmms_pkg::MaxSamples);

	logic signed [SW-1:0] mem [pmms_pkg::MaxSamples];
	logic signed [SW-1:0] rd_q, min_q, max_q, mean_q;
	logic signed [UW-1:0] sum_q;
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;

	// mean: restoring divide of |sum| by count, one quotient bit a cycle
	logic [UW-1:0] dnum_q, dquo_q;
	logic [CW:0]   drem_q;
	logic [$clog2(UW+1)-1:0] dbit_q;
	logic dbusy_q, dneg_q;
	logic [CW:0] drem_sh;
	logic [UW-1:0] dquo_fix;
	assign drem_sh  = {drem_q[CW-1:0], dnum_q[UW-1]};
	assign dquo_fix = dneg_q ? (~dquo_q + UW'(1)) : dquo_q;

	// second pass: read, diff, square, accumulate
	logic [AW-1:0] raddr_q;
	logic [CW-1:0] rcnt_q;
	logic pbusy_q, v1_q, v2_q, v3_q;
	logic signed [DW-1:0] d_s2;
	logic [QW-1:0] sq_s3;
	logic [XW-1:0] acc_q;
	logic [XW:0]   acc_sum;
	assign acc_sum = {1'b0, acc_q} + (XW+1)'(sq_s3);

	// variance: restoring divide of acc by count
	logic [XW-1:0] vnum_q, vquo_q;
	logic [CW:0]   vrem_q;
	logic [$clog2(XW+1)-1:0] vbit_q;
	logic vbusy_q;
	logic [CW:0] vrem_sh;
	assign vrem_sh = {vrem_q[CW-1:0], vnum_q[XW-1]};

	// square root, two radicand bits a cycle
	logic [XW-1:0] rx_q;
	logic [RW-1:0] rres_q;
	logic [RW+1:0] rrem_q;
	logic [$clog2(RW+1)-1:0] rbit_q;
	logic rbusy_q;
	logic [RW+1:0] rtrial, rrem_sh;
	assign rrem_sh = {rrem_q[RW-1:0], rx_q[XW-1:XW-2]};
	assign rtrial  = {rres_q, 2'b01};

	// last step of each unit
	logic div_last, pass_last, var_last, root_last;
	assign div_last  = dbusy_q && !ctl.div_start && (dbit_q == ($bits(dbit_q))'(UW - 1));
	assign pass_last = !pbusy_q && !v1_q && !v2_q && v3_q;
	assign var_last  = vbusy_q && !ctl.var_start && (vbit_q == ($bits(vbit_q))'(XW - 1));
	assign root_last = rbusy_q && !ctl.root_start && (rbit_q == ($bits(rbit_q))'(RW - 1));

	always_ff @(posedge clk) begin
		if (ctl.load && cnt_q < Full) mem[cnt_q[AW-1:0]] <= sample;
		rd_q <= mem[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= {1'b0, {(SW-1){1'b1}}};
			max_q <= {1'b1, {(SW-1){1'b0}}};
			sum_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
			dbusy_q <= 1'b0; pbusy_q <= 1'b0; vbusy_q <= 1'b0; rbusy_q <= 1'b0;
			v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
			sts <= '0;
		end else begin
			sts <= {div_last, pass_last, var_last, root_last};
			if (ctl.clear) begin
				min_q <= {1'b0, {(SW-1){1'b1}}};
				max_q <= {1'b1, {(SW-1){1'b0}}};
				sum_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
			end else if (ctl.load) begin
				if (cnt_q < Full) begin
					cnt_q <= cnt_q + CW'(1);
					if (sample < min_q) min_q <= sample;
					if (sample > max_q) max_q <= sample;
					sum_q <= sum_q + UW'(sample);
				end else ovf_q <= 1'b1;
			end
			if (ctl.div_start) begin
				dnum_q <= sum_q[UW-1] ? (~sum_q + UW'(1)) : sum_q;
				dneg_q <= sum_q[UW-1];
				drem_q <= '0; dquo_q <= '0;
				dbit_q <= '0; dbusy_q <= 1'b1;
			end else if (dbusy_q) begin
				dnum_q <= dnum_q << 1;
				if (drem_sh >= {1'b0, cnt_q}) begin
					drem_q <= drem_sh - {1'b0, cnt_q};
					dquo_q <= {dquo_q[UW-2:0], 1'b1};
				end else begin
					drem_q <= drem_sh;
					dquo_q <= {dquo_q[UW-2:0], 1'b0};
				end
				dbit_q <= dbit_q + ($bits(dbit_q))'(1);
				if (div_last) dbusy_q <= 1'b0;
			end
			if (sts.div_done) mean_q <= dquo_fix[SW-1:0];
			if (ctl.pass_start) begin
				raddr_q <= '0; rcnt_q <= '0; pbusy_q <= 1'b1; acc_q <= '0;
			end else if (pbusy_q) begin
				raddr_q <= raddr_q + AW'(1);
				rcnt_q  <= rcnt_q + CW'(1);
				if (rcnt_q + CW'(1) == cnt_q) pbusy_q <= 1'b0;
			end
			v1_q <= pbusy_q;
			v2_q <= v1_q;
			v3_q <= v2_q;
			if (v1_q) d_s2 <= DW'(rd_q) - DW'(mean_q);
			if (v2_q) sq_s3 <= QW'(d_s2 * d_s2);
			if (v3_q) acc_q <= acc_sum[XW] ? {XW{1'b1}} : acc_sum[XW-1:0];
			if (ctl.var_start) begin
				vnum_q <= acc_q; vrem_q <= '0; vquo_q <= '0;
				vbit_q <= '0; vbusy_q <= 1'b1;
			end else if (vbusy_q) begin
				vnum_q <= vnum_q << 1;
				if (vrem_sh >= {1'b0, cnt_q}) begin
					vrem_q <= vrem_sh - {1'b0, cnt_q};
					vquo_q <= {vquo_q[XW-2:0], 1'b1};
				end else begin
					vrem_q <= vrem_sh;
					vquo_q <= {vquo_q[XW-2:0], 1'b0};
				end
				vbit_q <= vbit_q + ($bits(vbit_q))'(1);
				if (var_last) vbusy_q <= 1'b0;
			end
			if (ctl.root_start) begin
				rx_q <= vquo_q; rres_q <= '0; rrem_q <= '0;
				rbit_q <= '0; rbusy_q <= 1'b1;
			end else if (rbusy_q) begin
				rx_q <= rx_q << 2;
				if (rrem_sh >= rtrial) begin
					rrem_q <= rrem_sh - rtrial;
					rres_q <= {rres_q[RW-2:0], 1'b1};
				end else begin
					rrem_q <= rrem_sh;
					rres_q <= {rres_q[RW-2:0], 1'b0};
				end
				rbit_q <= rbit_q + ($bits(rbit_q))'(1);
				if (root_last) rbusy_q <= 1'b0;
			end
		end
	end

	assign min_out   = min_q;
	assign max_out   = max_q;
	assign mean_out  = mean_q;
	assign sd_out    = (|rres_q[RW-1:SW]) ? {SW{1'b1}} : rres_q[SW-1:0];
	assign count_out = cnt_q[pmms_pkg::OutCntWidth-1:0];
	assign ovf_out   = ovf_q;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Full) else $error("count beyond capacity");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dbusy_q, pbusy_q, vbusy_q, rbusy_q})) else $error("units overlap");
	a_root_fit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rbusy_q) |-> sts.root_done) else $error("root done missing");
endmodule

[design/population_min_max_mean_stddev_unit.sv]
// channel  | dir | payload
// in_ch    | in  | fitness_value[23:0] signed, last_value
// out_ch   | out | minimum, maximum, mean_value, std_deviation, sample_count, overflowed
// Loading takes one sample per cycle. After the last sample, serial units
// run in order: the mean divide, a second pass over the stored samples, the
// variance divide and the square root. arst_n clears control and running
// state; the sample memory is not cleared. Input is held off from the last
// sample until the result request is taken.
module population_min_max_mean_stddev_unit (
	input logic             clk,
	input logic             arst_n,
	pmms_stream_if.sink     in_ch,
	pmms_stream_if.source   out_ch
);
	localparam int SW = pmms_pkg::SampleWidth;

	pmms_pkg::ctl_t ctl;
	pmms_pkg::sts_t sts;
	logic signed [SW-1:0] min_v, max_v, mean_v;
	logic [SW-1:0] sd_v;
	logic [pmms_pkg::OutCntWidth-1:0] cnt_v;
	logic ovf_v;

	pmms_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_last(in_ch.data[0]), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.ctl, .sts
	);

	pmms_datapath u_dp (
		.clk, .arst_n, .ctl, .sts,
		.sample(in_ch.data[SW:1]),
		.min_out(min_v), .max_out(max_v), .mean_out(mean_v),
		.sd_out(sd_v), .count_out(cnt_v), .ovf_out(ovf_v)
	);

	assign out_ch.data = {min_v, max_v, mean_v, sd_v, cnt_v, ovf_v};
endmodule
